// File: hdl/fcba_pkg.sv
package fcba_pkg;

  // Command codes of the input channel.
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_ERROR   = 2'd2;

  localparam logic [15:0] END_MARK  = 16'hffff;
  localparam logic [12:0] CFG_RESET = 13'd4096;

  // The free map is kept as words of this many bits.
  localparam int MAP_WORD_W = 64;
  localparam int MAP_BIT_W  = 6;
  // Width used for comparing block counts against word bases.
  localparam int CMP_W      = 17;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_APP_PREV,
    S_APP_END,
    S_WALK_CHECK,
    S_WALK_WR,
    S_QUERY,
    S_DONE
  } fcba_state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_SCAN_START,
    DP_SCAN_NEXT,
    DP_SCAN_HIT,
    DP_LINK_PREV,
    DP_LINK_END,
    DP_WALK_INIT,
    DP_WALK_RD,
    DP_WALK_WR,
    DP_QRY_RD,
    DP_SET_LINK,
    DP_SET_ERR,
    DP_SET_NOSPACE,
    DP_SET_FREED,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       blk_oor;
    logic       blk_zero;
    logic       scan_found;
    logic       scan_last;
    logic       walk_end;
    logic       walk_bad;
    logic       clr_done;
  } dp_stat_t;

endpackage

// File: hdl/fcba_if.sv
interface fcba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] block;

  modport source (output valid, output cmd, output block, input ready);
  modport sink   (input valid, input cmd, input block, output ready);
endinterface

interface fcba_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_block;
  logic [1:0]  status;

  modport source (output valid, output result_block, output status, input ready);
  modport sink   (input valid, input result_block, input status, output ready);
endinterface

interface fcba_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/fcba_ctrl.sv
module fcba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  fcba_pkg::dp_stat_t stat,
  output fcba_pkg::dp_op_t   op
);
  import fcba_pkg::*;

  fcba_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:      if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE:       if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_APPEND: state_nxt = stat.blk_oor ? S_DONE : S_SCAN;
          CMD_FREE:   state_nxt = S_WALK_CHECK;
          CMD_QUERY:  state_nxt = stat.blk_oor ? S_DONE : S_QUERY;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        priority if (stat.scan_found) state_nxt = S_APP_PREV;
        else if (stat.scan_last)      state_nxt = S_DONE;
        else                          state_nxt = S_SCAN;
      end
      S_APP_PREV:   state_nxt = S_APP_END;
      S_APP_END:    state_nxt = S_DONE;
      S_WALK_CHECK: state_nxt = (stat.walk_end || stat.walk_bad) ? S_DONE : S_WALK_WR;
      S_WALK_WR:    state_nxt = S_WALK_CHECK;
      S_QUERY:      state_nxt = S_DONE;
      S_DONE:       if (out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    op            = DP_NOP;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: op = DP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = DP_LOAD;
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_APPEND: op = stat.blk_oor ? DP_SET_ERR : DP_SCAN_START;
          CMD_FREE:   op = DP_WALK_INIT;
          CMD_QUERY:  op = stat.blk_oor ? DP_SET_ERR : DP_QRY_RD;
          default:    op = DP_SET_ERR;
        endcase
      end
      S_SCAN: begin
        priority if (stat.scan_found) op = DP_SCAN_HIT;
        else if (stat.scan_last)      op = DP_SET_NOSPACE;
        else                          op = DP_SCAN_NEXT;
      end
      S_APP_PREV: op = stat.blk_zero ? DP_NOP : DP_LINK_PREV;
      S_APP_END:  op = DP_LINK_END;
      S_WALK_CHECK: begin
        priority if (stat.walk_end) op = DP_SET_FREED;
        else if (stat.walk_bad)     op = DP_SET_ERR;
        else                        op = DP_WALK_RD;
      end
      S_WALK_WR: op = DP_WALK_WR;
      S_QUERY:   op = DP_SET_LINK;
      S_DONE: begin
        if (out_free) begin
          op            = DP_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      default: op = DP_NOP;
    endcase
  end

endmodule

// File: hdl/fcba_datapath.sv
module fcba_datapath #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcba_pkg::dp_op_t   op,
  output fcba_pkg::dp_stat_t stat,
  input  logic [1:0]         in_cmd,
  input  logic [15:0]        in_block,
  input  logic               cfg_valid,
  input  logic [12:0]        cfg_data,
  output logic [15:0]        out_result_block,
  output logic [1:0]         out_status
);
  import fcba_pkg::*;

  localparam int AW  = $clog2(MAX_BLOCKS + 1);
  localparam int NW  = (MAX_BLOCKS + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;

  logic [15:0]           link_mem [0:MAX_BLOCKS];
  logic [MAP_WORD_W-1:0] map_mem  [0:NW-1];
  logic [15:0]           link_rd_r;
  logic [MAP_WORD_W-1:0] map_rd_r;

  logic [1:0]     cmd_r;
  logic [15:0]    blk_r;
  logic [15:0]    cur_r;
  logic [AW-1:0]  steps_r;
  logic [WAW-1:0] word_r;
  logic [15:0]    res_r;
  logic [1:0]     st_r;
  logic [15:0]    out_res_r;
  logic [1:0]     out_st_r;
  logic [12:0]    cfg_r;
  logic [AW-1:0]  clr_r;

  logic [CMP_W-1:0]      cfg_ext, max_ext, lim, base, span;
  logic [MAP_WORD_W-1:0] mask, free_bits, hit_bit, cur_clr;
  logic [MAP_BIT_W-1:0]  pe;
  logic                  found;
  logic [15:0]           new_blk, cur_idx;
  logic [WAW-1:0]        cur_word;

  logic                  link_we, map_we;
  logic [AW-1:0]         link_waddr, link_raddr;
  logic [15:0]           link_wdata;
  logic [WAW-1:0]        map_waddr, map_raddr;
  logic [MAP_WORD_W-1:0] map_wdata;

  // Usable block count is the register clipped to the map size.
  assign cfg_ext = CMP_W'(cfg_r);
  assign max_ext = CMP_W'(MAX_BLOCKS);
  assign lim     = (cfg_ext > max_ext) ? max_ext : cfg_ext;
  assign base    = CMP_W'({word_r, {MAP_BIT_W{1'b0}}});
  assign span    = lim - base;

  // Bits of the current map word that fall inside the usable range.
  always_comb begin
    if (lim <= base) begin
      mask = '0;
    end else if (span >= CMP_W'(MAP_WORD_W)) begin
      mask = '1;
    end else begin
      mask = (MAP_WORD_W'(1) << span[MAP_BIT_W-1:0]) - MAP_WORD_W'(1);
    end
  end

  assign free_bits = ~map_rd_r & mask;
  assign found     = |free_bits;

  always_comb begin
    pe = '0;
    for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) pe = MAP_BIT_W'(i);
    end
  end

  assign hit_bit  = MAP_WORD_W'(1) << pe;
  assign new_blk  = 16'({word_r, pe}) + 16'd1;
  assign cur_idx  = cur_r - 16'd1;
  assign cur_word = cur_idx[MAP_BIT_W +: WAW];
  assign cur_clr  = ~(MAP_WORD_W'(1) << cur_idx[MAP_BIT_W-1:0]);

  always_comb begin
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_raddr = '0;
    map_we     = 1'b0;
    map_waddr  = '0;
    map_wdata  = '0;
    map_raddr  = '0;
    unique case (op)
      DP_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_r;
        map_we     = (32'(clr_r) < NW);
        map_waddr  = clr_r[WAW-1:0];
      end
      DP_SCAN_START: map_raddr = '0;
      DP_SCAN_NEXT:  map_raddr = word_r + WAW'(1);
      DP_SCAN_HIT: begin
        map_we    = 1'b1;
        map_waddr = word_r;
        map_wdata = map_rd_r | hit_bit;
      end
      DP_LINK_PREV: begin
        link_we    = 1'b1;
        link_waddr = blk_r[AW-1:0];
        link_wdata = res_r;
      end
      DP_LINK_END: begin
        link_we    = 1'b1;
        link_waddr = res_r[AW-1:0];
        link_wdata = END_MARK;
      end
      DP_WALK_RD: begin
        link_raddr = cur_r[AW-1:0];
        map_raddr  = cur_word;
      end
      DP_WALK_WR: begin
        link_we    = 1'b1;
        link_waddr = cur_r[AW-1:0];
        map_we     = 1'b1;
        map_waddr  = cur_word;
        map_wdata  = map_rd_r & cur_clr;
      end
      DP_QRY_RD: link_raddr = blk_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rd_r <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rd_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
      clr_r <= '0;
    end else begin
      if (cfg_valid) cfg_r <= cfg_data;
      if (op == DP_CLEAR) clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      DP_LOAD: begin
        cmd_r <= in_cmd;
        blk_r <= in_block;
      end
      DP_SCAN_START: word_r <= '0;
      DP_SCAN_NEXT:  word_r <= word_r + WAW'(1);
      DP_SCAN_HIT: begin
        res_r <= new_blk;
        st_r  <= STAT_OK;
      end
      DP_WALK_INIT: begin
        cur_r   <= blk_r;
        steps_r <= '0;
      end
      DP_WALK_WR: begin
        cur_r   <= link_rd_r;
        steps_r <= steps_r + AW'(1);
      end
      DP_SET_LINK: begin
        res_r <= link_rd_r;
        st_r  <= STAT_OK;
      end
      DP_SET_ERR: begin
        res_r <= '0;
        st_r  <= STAT_ERROR;
      end
      DP_SET_NOSPACE: begin
        res_r <= '0;
        st_r  <= STAT_NOSPACE;
      end
      DP_SET_FREED: begin
        res_r <= '0;
        st_r  <= STAT_OK;
      end
      DP_OUT: begin
        out_res_r <= res_r;
        out_st_r  <= st_r;
      end
      default: ;
    endcase
  end

  assign out_result_block = out_res_r;
  assign out_status       = out_st_r;

  assign stat.cmd        = cmd_r;
  assign stat.blk_oor    = blk_r > 16'(MAX_BLOCKS);
  assign stat.blk_zero   = (blk_r == 16'd0);
  assign stat.scan_found = found;
  assign stat.scan_last  = (base + CMP_W'(MAP_WORD_W)) >= lim;
  assign stat.walk_end   = (cur_r == END_MARK);
  assign stat.walk_bad   = (cur_r == 16'd0) || (cur_r > 16'(MAX_BLOCKS)) ||
                           (steps_r == AW'(MAX_BLOCKS));
  assign stat.clr_done   = (clr_r == AW'(MAX_BLOCKS));

endmodule

// File: hdl/fat_chain_block_allocator.sv
// Per item: a link query reads the link table, an append scans W 64-bit free-map
// words (W up to ceil(blocks/64)), and a free walks a chain of N blocks.
// One item is in work at a time; the next is taken the cycle after the result is registered.
// After reset the block clears its link table and free map and accepts no item
// meanwhile; configuration writes are taken at all times.
module fat_chain_block_allocator #(
  parameter int MAX_BLOCKS = 4096
) (
  input logic       clk,
  input logic       rst_n,
  fcba_in_if.sink   in_chan,
  fcba_out_if.source out_chan,
  fcba_cfg_if.sink  cfg_chan
);
  import fcba_pkg::*;

  // The controller sequences each command as a series of datapath operations
  // and reads back a small set of status flags; the datapath owns the link
  // table, the free map, the configuration register and the result register.
  dp_op_t   op;
  dp_stat_t stat;

  // The single configuration register can be written in any cycle.
  assign cfg_chan.ready = 1'b1;

  fcba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .stat      (stat),
    .op        (op)
  );

  // Appends scan the free map one word per cycle from the lowest block and
  // take the lowest free bit. Frees follow the chain one block at a time,
  // reading the link and the map word, then writing both back cleared.
  // A visited link reads as zero, so a looping chain ends in an error.
  fcba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .in_cmd           (in_chan.cmd),
    .in_block         (in_chan.block),
    .cfg_valid        (cfg_chan.valid),
    .cfg_data         (cfg_chan.data),
    .out_result_block (out_chan.result_block),
    .out_status       (out_chan.status)
  );

endmodule
